### rtl/core/glw_pkg.sv
// ----------------------------------------------------------------------------
// glw_pkg
// Shared types, register codes and helpers of the greedy line wrap placer.
// ----------------------------------------------------------------------------
package glw_pkg;

    localparam int CFG_IDX_BITS = 8;
    localparam int CELL_BITS    = 10;
    localparam int BYTE_BITS    = 14;

    localparam logic [CFG_IDX_BITS-1:0] REG_LINE_WIDTH     = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_FIRST_INDENT   = 8'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_HANGING_INDENT = 8'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_TAB_STOP       = 8'd3;

    localparam logic [7:0] RST_LINE_WIDTH     = 8'd80;
    localparam logic [7:0] RST_FIRST_INDENT   = 8'd0;
    localparam logic [7:0] RST_HANGING_INDENT = 8'd0;
    localparam logic [7:0] RST_TAB_STOP       = 8'd8;
    localparam logic [7:0] DEFAULT_TAB        = 8'd8;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LATCH,
        OP_DISPATCH,
        OP_RESTART,
        OP_XFER,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_TAB_INIT,
        OP_SET_DROP,
        OP_PLACE_TAB,
        OP_PLACE_IN,
        OP_SETUP_CUT,
        OP_RD_HEAD,
        OP_EV_HEAD,
        OP_BRK2,
        OP_RD_STRIP,
        OP_EV_STRIP,
        OP_SCLOSE,
        OP_CL1,
        OP_CL2,
        OP_CL3,
        OP_CL4
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic eot;
        logic nl;
        logic tab;
        logic sp;
        logic cw_nz;
        logic nlo;
        logic eot_close;
        logic drop;
        logic over;
        logic tab_over;
        logic full;
        logic lbp_ok;
        logic cnt_zero;
        logic head_zero;
        logic rd_space;
        logic k_zero;
        logic bit_zero;
        logic stg_empty;
        logic q_empty;
    } stat_t;

    typedef struct packed {
        logic [8:0]  cluster_total;
        logic [13:0] byte_total;
        logic [7:0]  line_cells;
        logic [7:0]  line_indent;
        logic        hard_break;
        logic        last_of_run;
    } rec_t;

    typedef struct packed {
        logic [8:0] room;
        logic [7:0] indent;
    } ls_t;

    function automatic ls_t line_start(input logic [7:0] lw, input logic [7:0] fi,
                                       input logic [7:0] hi, input logic first);
        ls_t r;
        logic [7:0] ind;
        ind = first ? fi : hi;
        if (lw != 8'd0 && ind >= lw)
        begin
            ind = lw - 8'd1;
        end
        r.indent = ind;
        r.room   = (lw == 8'd0) ? 9'd0 : ({1'b0, lw} - {1'b0, ind});
        return r;
    endfunction

endpackage

### rtl/core/glw_if.sv
// ----------------------------------------------------------------------------
// glw_if
// Channel interfaces: cluster input, line record output, register writes.
// ----------------------------------------------------------------------------
interface glw_in_if #(parameter int OB = 32);
    logic          valid;
    logic          ready;
    logic          end_of_text;
    logic [1:0]    cell_width;
    logic [5:0]    byte_count;
    logic          break_before;
    logic          is_space;
    logic          is_tab;
    logic          is_newline;
    logic [OB-1:0] source_offset;

    modport source (output valid, end_of_text, cell_width, byte_count, break_before,
                    is_space, is_tab, is_newline, source_offset, input ready);
    modport sink (input valid, end_of_text, cell_width, byte_count, break_before,
                  is_space, is_tab, is_newline, source_offset, output ready);
endinterface

interface glw_out_if #(parameter int OB = 32);
    logic          valid;
    logic          ready;
    logic [OB-1:0] first_source;
    logic [8:0]    cluster_total;
    logic [13:0]   byte_total;
    logic [7:0]    line_cells;
    logic [7:0]    line_indent;
    logic          hard_break;
    logic          last_of_run;

    modport source (output valid, first_source, cluster_total, byte_total, line_cells,
                    line_indent, hard_break, last_of_run, input ready);
    modport sink (input valid, first_source, cluster_total, byte_total, line_cells,
                  line_indent, hard_break, last_of_run, output ready);
endinterface

interface glw_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] index;
    logic [7:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/glw_ram.sv
// ----------------------------------------------------------------------------
// glw_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module glw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/glw_datapath.sv
// ----------------------------------------------------------------------------
// glw_datapath
// Line store (circular, prefix sums per entry), counters, tab divider and
// record buffers, driven by one command per cycle.
// ----------------------------------------------------------------------------
module glw_datapath
    import glw_pkg::*;
#(
    parameter int MAX_LINE_CLUSTERS = 256,
    parameter int OFFSET_BITS       = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  cmd_t                   cmd,
    output stat_t                  st,
    input  logic                   in_eot,
    input  logic [1:0]             in_cw,
    input  logic [5:0]             in_nb,
    input  logic                   in_brk,
    input  logic                   in_sp,
    input  logic                   in_tab,
    input  logic                   in_nl,
    input  logic [OFFSET_BITS-1:0] in_org,
    input  logic                   cfg_valid,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [7:0]             cfg_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [OFFSET_BITS-1:0] out_org,
    output rec_t                   out_rec
);

    localparam int PB = $clog2(MAX_LINE_CLUSTERS);
    localparam int CB = PB + 1;
    localparam int OB = OFFSET_BITS;
    localparam int W  = 1 + CELL_BITS + BYTE_BITS + OB;
    localparam ls_t RST_LS = line_start(RST_LINE_WIDTH, RST_FIRST_INDENT,
                                        RST_HANGING_INDENT, 1'b1);

    // config
    logic [7:0] lw_reg, fi_reg, hi_reg, ts_reg;

    // control state
    logic [CB-1:0]        cnt_reg, cnt_next;
    logic [PB-1:0]        base_reg, base_next;
    logic [CELL_BITS-1:0] acc_c_reg, acc_c_next, base_c_reg, base_c_next;
    logic [BYTE_BITS-1:0] acc_b_reg, acc_b_next, base_b_reg, base_b_next;
    logic [7:0]           indent_reg, indent_next;
    logic [8:0]           room_reg, room_next;
    logic [CB-1:0]        lbp_reg, lbp_next;
    logic                 any_reg, any_next, pend_reg, pend_next, drop_reg, drop_next;
    logic [CB-1:0]        head_reg, head_next, keep_reg, keep_next;
    logic                 hard_reg, hard_next;
    logic [3:0]           bit_reg, bit_next;
    logic [7:0]           k_reg, k_next;
    logic [1:0]           stg_n_reg, stg_n_next, q_cnt_reg, q_cnt_next;

    // payload
    logic                 eot_reg, eot_next, brk_reg, brk_next, sp_reg, sp_next;
    logic                 tab_reg, tab_next, nl_reg, nl_next;
    logic [1:0]           cw_reg, cw_next;
    logic [5:0]           nb_reg, nb_next;
    logic [OB-1:0]        org_reg, org_next;
    logic [7:0]           tw_reg, tw_next, rem_reg, rem_next;
    logic [CELL_BITS-1:0] ph_c_reg, ph_c_next, pk_c_reg, pk_c_next;
    logic [BYTE_BITS-1:0] ph_b_reg, ph_b_next, pk_b_reg, pk_b_next;
    rec_t                 stg_rec_reg [2];
    rec_t                 stg_rec_next [2];
    logic [OB-1:0]        stg_org_reg [2];
    logic [OB-1:0]        stg_org_next [2];
    rec_t                 q_rec_reg [2];
    rec_t                 q_rec_next [2];
    logic [OB-1:0]        q_org_reg [2];
    logic [OB-1:0]        q_org_next [2];

    // store
    logic          we;
    logic [PB-1:0] waddr, raddr;
    logic [W-1:0]  wdata, rdata;
    logic          rd_sp;
    logic [CELL_BITS-1:0] rd_pc;
    logic [BYTE_BITS-1:0] rd_pb;
    logic [OB-1:0] rd_org;

    logic [CELL_BITS-1:0] held_c;
    logic [8:0]    t9;
    logic [31:0]   head_w;
    logic          full;
    ls_t           ls_next;

    glw_ram #(.WIDTH(W), .DEPTH(MAX_LINE_CLUSTERS)) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rd_org = rdata[OB-1:0];
    assign rd_pb  = rdata[OB+BYTE_BITS-1:OB];
    assign rd_pc  = rdata[OB+BYTE_BITS+CELL_BITS-1:OB+BYTE_BITS];
    assign rd_sp  = rdata[W-1];

    assign held_c = acc_c_reg - base_c_reg;
    assign full   = (cnt_reg == CB'(MAX_LINE_CLUSTERS));
    assign head_w = 32'(head_reg);
    assign ls_next = line_start(lw_reg, fi_reg, hi_reg, 1'b0);

    always_comb
    begin
        st.eot       = eot_reg;
        st.nl        = nl_reg;
        st.tab       = tab_reg;
        st.sp        = sp_reg;
        st.cw_nz     = (cw_reg != 2'd0);
        st.nlo       = (lw_reg == 8'd0);
        st.eot_close = pend_reg || !any_reg;
        st.drop      = drop_reg;
        st.over      = (11'(held_c) + 11'(cw_reg)) > 11'(room_reg);
        st.tab_over  = ((11'(held_c) + 11'd1) > 11'(room_reg)) || full;
        st.full      = full;
        st.lbp_ok    = (lbp_reg != '0) && (lbp_reg < cnt_reg);
        st.cnt_zero  = (cnt_reg == '0);
        st.head_zero = (head_reg == '0);
        st.rd_space  = rd_sp;
        st.k_zero    = (k_reg == 8'd0);
        st.bit_zero  = (bit_reg == 4'd0);
        st.stg_empty = (stg_n_reg == 2'd0);
        st.q_empty   = (q_cnt_reg == 2'd0);
    end

    assign out_valid = (q_cnt_reg != 2'd0);
    assign out_rec   = q_rec_reg[0];
    assign out_org   = q_org_reg[0];

    always_comb
    begin
        cnt_next = cnt_reg;     base_next = base_reg;
        acc_c_next = acc_c_reg; acc_b_next = acc_b_reg;
        base_c_next = base_c_reg; base_b_next = base_b_reg;
        indent_next = indent_reg; room_next = room_reg;
        lbp_next = lbp_reg; any_next = any_reg; pend_next = pend_reg; drop_next = drop_reg;
        head_next = head_reg; keep_next = keep_reg; hard_next = hard_reg;
        bit_next = bit_reg; k_next = k_reg;
        stg_n_next = stg_n_reg; q_cnt_next = q_cnt_reg;
        eot_next = eot_reg; brk_next = brk_reg; sp_next = sp_reg; tab_next = tab_reg;
        nl_next = nl_reg; cw_next = cw_reg; nb_next = nb_reg; org_next = org_reg;
        tw_next = tw_reg; rem_next = rem_reg;
        ph_c_next = ph_c_reg; ph_b_next = ph_b_reg; pk_c_next = pk_c_reg; pk_b_next = pk_b_reg;
        stg_rec_next = stg_rec_reg; stg_org_next = stg_org_reg;
        q_rec_next = q_rec_reg; q_org_next = q_org_reg;
        we = 1'b0;
        waddr = base_reg + cnt_reg[PB-1:0];
        wdata = {sp_reg, acc_c_reg, acc_b_reg, org_reg};
        raddr = base_reg;
        t9 = {rem_reg, held_c[bit_reg]};

        if (out_valid && out_ready)
        begin
            q_rec_next[0] = q_rec_reg[1];
            q_org_next[0] = q_org_reg[1];
            q_cnt_next    = q_cnt_reg - 2'd1;
        end

        case (cmd.op)
            OP_LATCH:
            begin
                eot_next = in_eot; cw_next = in_cw; nb_next = in_nb; brk_next = in_brk;
                sp_next = in_sp; tab_next = in_tab; nl_next = in_nl; org_next = in_org;
                stg_n_next = 2'd0;
            end
            OP_DISPATCH:
            begin
                if (!eot_reg && !nl_reg)
                begin
                    if (brk_reg)
                    begin
                        lbp_next = cnt_reg;
                    end
                    if (cw_reg != 2'd0 || tab_reg || sp_reg)
                    begin
                        pend_next = 1'b1;
                    end
                end
                head_next = cnt_reg;
                keep_next = cnt_reg;
                hard_next = 1'b1;
            end
            OP_RESTART:
            begin
                cnt_next = '0; base_next = '0;
                acc_c_next = '0; acc_b_next = '0; base_c_next = '0; base_b_next = '0;
                lbp_next = '0; any_next = 1'b0; pend_next = 1'b0; drop_next = 1'b0;
                {room_next, indent_next} = line_start(lw_reg, fi_reg, hi_reg, 1'b1);
            end
            OP_XFER:
            begin
                if (stg_n_reg != 2'd0)
                begin
                    q_rec_next[0] = stg_rec_reg[0];
                    q_rec_next[1] = stg_rec_reg[1];
                    q_org_next[0] = stg_org_reg[0];
                    q_org_next[1] = stg_org_reg[1];
                    q_rec_next[0].last_of_run = (stg_n_reg == 2'd1);
                    q_rec_next[1].last_of_run = 1'b1;
                    q_cnt_next = stg_n_reg;
                end
            end
            OP_DIV_INIT:
            begin
                rem_next = 8'd0;
                bit_next = 4'(CELL_BITS - 1);
                tw_next  = (ts_reg != 8'd0) ? ts_reg : DEFAULT_TAB;
            end
            OP_DIV_STEP:
            begin
                rem_next = (t9 >= {1'b0, tw_reg}) ? 8'(t9 - {1'b0, tw_reg}) : t9[7:0];
                bit_next = bit_reg - 4'd1;
            end
            OP_TAB_INIT:
            begin
                k_next = tw_reg - rem_reg;
            end
            OP_SET_DROP:
            begin
                drop_next = 1'b1;
            end
            OP_PLACE_TAB:
            begin
                we = 1'b1;
                wdata = {1'b1, acc_c_reg, acc_b_reg, org_reg};
                cnt_next = cnt_reg + CB'(1);
                acc_c_next = acc_c_reg + CELL_BITS'(1);
                acc_b_next = acc_b_reg + BYTE_BITS'(1);
                pend_next = 1'b1;
                k_next = k_reg - 8'd1;
            end
            OP_PLACE_IN:
            begin
                we = 1'b1;
                cnt_next = cnt_reg + CB'(1);
                acc_c_next = acc_c_reg + CELL_BITS'(cw_reg);
                acc_b_next = acc_b_reg + BYTE_BITS'(nb_reg);
                pend_next = 1'b1;
            end
            OP_SETUP_CUT:
            begin
                head_next = lbp_reg;
                keep_next = lbp_reg;
                hard_next = 1'b0;
            end
            OP_RD_HEAD:
            begin
                raddr = base_reg + head_reg[PB-1:0] - PB'(1);
            end
            OP_EV_HEAD:
            begin
                if (rd_sp)
                begin
                    head_next = head_reg - CB'(1);
                end
            end
            OP_BRK2:
            begin
                if (brk_reg)
                begin
                    lbp_next = cnt_reg;
                end
            end
            OP_RD_STRIP:
            begin
                raddr = base_reg + cnt_reg[PB-1:0] - PB'(1);
            end
            OP_EV_STRIP:
            begin
                if (rd_sp)
                begin
                    cnt_next = cnt_reg - CB'(1);
                    acc_c_next = rd_pc;
                    acc_b_next = rd_pb;
                end
            end
            OP_SCLOSE:
            begin
                head_next = cnt_reg;
                keep_next = cnt_reg;
                hard_next = 1'b0;
            end
            OP_CL1:
            begin
                raddr = base_reg + head_reg[PB-1:0];
            end
            OP_CL2:
            begin
                ph_c_next = (head_reg == cnt_reg) ? acc_c_reg : rd_pc;
                ph_b_next = (head_reg == cnt_reg) ? acc_b_reg : rd_pb;
                raddr = base_reg + keep_reg[PB-1:0];
            end
            OP_CL3:
            begin
                pk_c_next = (keep_reg == cnt_reg) ? acc_c_reg : rd_pc;
                pk_b_next = (keep_reg == cnt_reg) ? acc_b_reg : rd_pb;
                raddr = base_reg;
            end
            OP_CL4:
            begin
                if (stg_n_reg != 2'd2)
                begin
                    stg_org_next[stg_n_reg[0]] = (head_reg != '0) ? rd_org : '0;
                    stg_rec_next[stg_n_reg[0]].cluster_total = head_w[8:0];
                    stg_rec_next[stg_n_reg[0]].byte_total = ph_b_reg - base_b_reg;
                    stg_rec_next[stg_n_reg[0]].line_cells = 8'(ph_c_reg - base_c_reg);
                    stg_rec_next[stg_n_reg[0]].line_indent = indent_reg;
                    stg_rec_next[stg_n_reg[0]].hard_break = hard_reg;
                    stg_rec_next[stg_n_reg[0]].last_of_run = 1'b0;
                    stg_n_next = stg_n_reg + 2'd1;
                end
                cnt_next = cnt_reg - keep_reg;
                base_next = base_reg + keep_reg[PB-1:0];
                base_c_next = pk_c_reg;
                base_b_next = pk_b_reg;
                room_next = ls_next.room;
                indent_next = ls_next.indent;
                any_next = 1'b1;
                pend_next = (cnt_reg != keep_reg);
                lbp_next = '0;
                drop_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lw_reg <= RST_LINE_WIDTH;
            fi_reg <= RST_FIRST_INDENT;
            hi_reg <= RST_HANGING_INDENT;
            ts_reg <= RST_TAB_STOP;
            cnt_reg <= '0; base_reg <= '0;
            acc_c_reg <= '0; acc_b_reg <= '0; base_c_reg <= '0; base_b_reg <= '0;
            indent_reg <= RST_LS.indent;
            room_reg <= RST_LS.room;
            lbp_reg <= '0; any_reg <= 1'b0; pend_reg <= 1'b0; drop_reg <= 1'b0;
            head_reg <= '0; keep_reg <= '0; hard_reg <= 1'b0;
            bit_reg <= '0; k_reg <= '0;
            stg_n_reg <= '0; q_cnt_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_LINE_WIDTH:     lw_reg <= cfg_data;
                    REG_FIRST_INDENT:   fi_reg <= cfg_data;
                    REG_HANGING_INDENT: hi_reg <= cfg_data;
                    REG_TAB_STOP:       ts_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            cnt_reg <= cnt_next; base_reg <= base_next;
            acc_c_reg <= acc_c_next; acc_b_reg <= acc_b_next;
            base_c_reg <= base_c_next; base_b_reg <= base_b_next;
            indent_reg <= indent_next; room_reg <= room_next;
            lbp_reg <= lbp_next; any_reg <= any_next; pend_reg <= pend_next;
            drop_reg <= drop_next;
            head_reg <= head_next; keep_reg <= keep_next; hard_reg <= hard_next;
            bit_reg <= bit_next; k_reg <= k_next;
            stg_n_reg <= stg_n_next; q_cnt_reg <= q_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        eot_reg <= eot_next; brk_reg <= brk_next; sp_reg <= sp_next; tab_reg <= tab_next;
        nl_reg <= nl_next; cw_reg <= cw_next; nb_reg <= nb_next; org_reg <= org_next;
        tw_reg <= tw_next; rem_reg <= rem_next;
        ph_c_reg <= ph_c_next; ph_b_reg <= ph_b_next;
        pk_c_reg <= pk_c_next; pk_b_reg <= pk_b_next;
        stg_rec_reg <= stg_rec_next; stg_org_reg <= stg_org_next;
        q_rec_reg <= q_rec_next; q_org_reg <= q_org_next;
    end

endmodule

### rtl/core/glw_ctrl.sv
// ----------------------------------------------------------------------------
// glw_ctrl
// Sequencer of the placer: one command per cycle to the datapath.
// ----------------------------------------------------------------------------
module glw_ctrl
    import glw_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  stat_t st,
    output cmd_t  cmd
);

    typedef enum logic [22:0] {
        S_IDLE     = 23'h000001,
        S_DISPATCH = 23'h000002,
        S_RESTART  = 23'h000004,
        S_FINISH   = 23'h000008,
        S_DIV_INIT = 23'h000010,
        S_DIV_STEP = 23'h000020,
        S_TAB_INIT = 23'h000040,
        S_TAB_LOOP = 23'h000080,
        S_SPACE    = 23'h000100,
        S_VIS0     = 23'h000200,
        S_VIS1     = 23'h000400,
        S_HW_RD    = 23'h000800,
        S_HW_EV    = 23'h001000,
        S_VIS2     = 23'h002000,
        S_VIS3     = 23'h004000,
        S_VIS4     = 23'h008000,
        S_STRIP_RD = 23'h010000,
        S_STRIP_EV = 23'h020000,
        S_SCLOSE   = 23'h040000,
        S_CL1      = 23'h080000,
        S_CL2      = 23'h100000,
        S_CL3      = 23'h200000,
        S_CL4      = 23'h400000
    } state_t;

    state_t state_reg, state_next, ret_reg, ret_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        cmd.op     = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op = OP_LATCH;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                cmd.op = OP_DISPATCH;
                if (st.eot)
                begin
                    ret_next = S_RESTART;
                    state_next = st.eot_close ? S_CL1 : S_RESTART;
                end
                else if (st.nl)
                begin
                    ret_next = S_FINISH;
                    state_next = S_CL1;
                end
                else if (st.tab)
                begin
                    state_next = st.nlo ? S_FINISH : S_DIV_INIT;
                end
                else if (st.cw_nz && !st.nlo)
                begin
                    state_next = st.sp ? S_SPACE : S_VIS0;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_RESTART:
            begin
                cmd.op = OP_RESTART;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (st.stg_empty || st.q_empty)
                begin
                    cmd.op = OP_XFER;
                    state_next = S_IDLE;
                end
            end
            S_DIV_INIT:
            begin
                cmd.op = OP_DIV_INIT;
                state_next = S_DIV_STEP;
            end
            S_DIV_STEP:
            begin
                cmd.op = OP_DIV_STEP;
                if (st.bit_zero)
                begin
                    state_next = S_TAB_INIT;
                end
            end
            S_TAB_INIT:
            begin
                cmd.op = OP_TAB_INIT;
                state_next = S_TAB_LOOP;
            end
            S_TAB_LOOP:
            begin
                if (st.k_zero)
                begin
                    state_next = S_FINISH;
                end
                else if (st.tab_over)
                begin
                    cmd.op = OP_SET_DROP;
                    state_next = S_FINISH;
                end
                else if (st.drop)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.op = OP_PLACE_TAB;
                end
            end
            S_SPACE:
            begin
                cmd.op = (st.drop || st.over || st.full) ? OP_SET_DROP : OP_PLACE_IN;
                state_next = S_FINISH;
            end
            S_VIS0:
            begin
                if (st.drop)
                begin
                    ret_next = S_VIS1;
                    state_next = S_STRIP_RD;
                end
                else
                begin
                    state_next = S_VIS1;
                end
            end
            S_VIS1:
            begin
                if (st.over && !st.cnt_zero)
                begin
                    if (st.lbp_ok)
                    begin
                        cmd.op = OP_SETUP_CUT;
                        ret_next = S_VIS2;
                        state_next = S_HW_RD;
                    end
                    else
                    begin
                        ret_next = S_VIS3;
                        state_next = S_STRIP_RD;
                    end
                end
                else
                begin
                    state_next = S_VIS3;
                end
            end
            S_HW_RD:
            begin
                if (st.head_zero)
                begin
                    state_next = S_CL1;
                end
                else
                begin
                    cmd.op = OP_RD_HEAD;
                    state_next = S_HW_EV;
                end
            end
            S_HW_EV:
            begin
                cmd.op = OP_EV_HEAD;
                state_next = st.rd_space ? S_HW_RD : S_CL1;
            end
            S_VIS2:
            begin
                cmd.op = OP_BRK2;
                if (st.over && !st.cnt_zero)
                begin
                    ret_next = S_VIS3;
                    state_next = S_STRIP_RD;
                end
                else
                begin
                    state_next = S_VIS3;
                end
            end
            S_VIS3:
            begin
                if (st.full)
                begin
                    ret_next = S_VIS4;
                    state_next = S_STRIP_RD;
                end
                else
                begin
                    state_next = S_VIS4;
                end
            end
            S_VIS4:
            begin
                cmd.op = OP_PLACE_IN;
                state_next = S_FINISH;
            end
            S_STRIP_RD:
            begin
                if (st.cnt_zero)
                begin
                    state_next = S_SCLOSE;
                end
                else
                begin
                    cmd.op = OP_RD_STRIP;
                    state_next = S_STRIP_EV;
                end
            end
            S_STRIP_EV:
            begin
                cmd.op = OP_EV_STRIP;
                state_next = st.rd_space ? S_STRIP_RD : S_SCLOSE;
            end
            S_SCLOSE:
            begin
                cmd.op = OP_SCLOSE;
                state_next = S_CL1;
            end
            S_CL1:
            begin
                cmd.op = OP_CL1;
                state_next = S_CL2;
            end
            S_CL2:
            begin
                cmd.op = OP_CL2;
                state_next = S_CL3;
            end
            S_CL3:
            begin
                cmd.op = OP_CL3;
                state_next = S_CL4;
            end
            S_CL4:
            begin
                cmd.op = OP_CL4;
                state_next = ret_reg;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

endmodule

### rtl/core/greedy_line_wrap_placer_core.sv
// ----------------------------------------------------------------------------
// greedy_line_wrap_placer_core
// Greedy line wrap: places classified clusters on lines, emits line records.
//
// channel  dir  carries
// in_ch    in   one cluster or end-of-text mark per request
// out_ch   out  one line record per request, last_of_run on the last of a run
// cfg      in   register write: index, data (always ready)
//
// A tab finds its column remainder bit-serially, then places one cell per expanded
// cell. A line close reads the store in steps CL1 to CL4, after a read and an
// evaluate step per space stripped or skipped at the cut (store read port).
// Reset restores registers to line width 80, indents 0, tab stop 8.
// Up to two records wait in an output buffer; the next request is taken while
// they drain, and a run that closes lines waits until the buffer is empty.
// ----------------------------------------------------------------------------
module greedy_line_wrap_placer_core
    import glw_pkg::*;
#(
    parameter int MAX_LINE_CLUSTERS = 256,
    parameter int OFFSET_BITS       = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    glw_in_if.sink     in_ch,
    glw_out_if.source  out_ch,
    glw_cfg_if.sink    cfg
);

    cmd_t  cmd;
    stat_t st;
    rec_t  rec;

    assign cfg.ready = 1'b1;

    glw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .st       (st),
        .cmd      (cmd)
    );

    glw_datapath #(
        .MAX_LINE_CLUSTERS (MAX_LINE_CLUSTERS),
        .OFFSET_BITS       (OFFSET_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .in_eot    (in_ch.end_of_text),
        .in_cw     (in_ch.cell_width),
        .in_nb     (in_ch.byte_count),
        .in_brk    (in_ch.break_before),
        .in_sp     (in_ch.is_space),
        .in_tab    (in_ch.is_tab),
        .in_nl     (in_ch.is_newline),
        .in_org    (in_ch.source_offset),
        .cfg_valid (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_org   (out_ch.first_source),
        .out_rec   (rec)
    );

    assign out_ch.cluster_total = rec.cluster_total;
    assign out_ch.byte_total    = rec.byte_total;
    assign out_ch.line_cells    = rec.line_cells;
    assign out_ch.line_indent   = rec.line_indent;
    assign out_ch.hard_break    = rec.hard_break;
    assign out_ch.last_of_run   = rec.last_of_run;

endmodule
